### src/sorted_hash_string_table_assert.svh
// Assertion macros used by the checker of the sorted hash string table
`ifndef SORTED_HASH_STRING_TABLE_ASSERT_SVH
`define SORTED_HASH_STRING_TABLE_ASSERT_SVH

// implication checked in the next cycle, off during reset
`define SHT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sht assertion failed");

// same-cycle implication, off during reset
`define SHT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sht assertion failed");

// implication in the next cycle, also checked across reset
`define SHT_ASSERT_RST(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("sht assertion failed");

`endif

### src/sht_pkg.sv
// Package of the sorted hash string table: codes, token type and defaults
`timescale 1ns / 1ps
package sht_pkg;

   localparam int SHT_TABLE_DEPTH  = 256;
   localparam int SHT_HEADER_BYTES = 12;

   // result status codes
   typedef enum logic [1:0] {
      ST_FOUND      = 2'd0,
      ST_ADDED      = 2'd1,
      ST_AREA_FULL  = 2'd2,
      ST_TABLE_FULL = 2'd3
   } status_type;

   // what a token moving down the cell chain carries
   typedef enum logic [1:0] {
      TK_IDLE   = 2'd0,
      TK_SEARCH = 2'd1,
      TK_SHIFT  = 2'd2,
      TK_DONE   = 2'd3
   } tok_kind_type;

   typedef struct packed {
      tok_kind_type kind;
      logic [31:0]  hash;
      logic [15:0]  len;
      logic [31:0]  off;
      status_type   stat;
   } tok_type;

endpackage

### src/sht_cell.sv
// One table slot of the sorted chain: holds an entry and passes a token on
`timescale 1ns / 1ps
module sht_cell
   import sht_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    ent_valid,
   input  tok_type up_tok,
   output tok_type dn_tok
);

   logic [31:0] ent_hash_ff, ent_hash_in;
   logic [15:0] ent_len_ff, ent_len_in;
   logic [31:0] ent_off_ff, ent_off_in;
   logic        ent_we;
   tok_type     tok_ff, tok_in;
   tok_type     old_tok;

   // displaced entry, or a done marker when this slot was empty
   always_comb begin
      old_tok = '0;
      if (ent_valid) begin
         old_tok.kind = TK_SHIFT;
         old_tok.hash = ent_hash_ff;
         old_tok.len  = ent_len_ff;
         old_tok.off  = ent_off_ff;
         old_tok.stat = ST_ADDED;
      end else begin
         old_tok.kind = TK_DONE;
         old_tok.stat = ST_ADDED;
      end
   end

   // token handling
   always_comb begin
      tok_in     = up_tok;
      ent_we     = 1'b0;
      ent_hash_in = up_tok.hash;
      ent_len_in  = up_tok.len;
      ent_off_in  = up_tok.off;
      unique case (up_tok.kind)
         TK_IDLE, TK_DONE: begin
            tok_in = up_tok;
         end
         TK_SEARCH: begin
            if (ent_valid && ent_hash_ff < up_tok.hash) begin
               tok_in = up_tok;
            end else if (ent_valid && ent_hash_ff == up_tok.hash) begin
               tok_in      = up_tok;
               tok_in.kind = TK_DONE;
               tok_in.stat = ST_FOUND;
               tok_in.off  = ent_off_ff;
               tok_in.len  = ent_len_ff;
            end else if (up_tok.stat != ST_ADDED) begin
               // insert point, but area or table has no room
               tok_in      = up_tok;
               tok_in.kind = TK_DONE;
               tok_in.off  = '0;
               tok_in.len  = '0;
            end else begin
               ent_we = 1'b1;
               tok_in = old_tok;
            end
         end
         TK_SHIFT: begin
            ent_we = 1'b1;
            tok_in = old_tok;
         end
         default: begin
            tok_in = up_tok;
         end
      endcase
   end

   // token register, only the kind needs reset
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.kind <= TK_IDLE;
      end else begin
         tok_ff.kind <= tok_in.kind;
      end
      tok_ff.hash <= tok_in.hash;
      tok_ff.len  <= tok_in.len;
      tok_ff.off  <= tok_in.off;
      tok_ff.stat <= tok_in.stat;
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_hash_ff <= ent_hash_in;
         ent_len_ff  <= ent_len_in;
         ent_off_ff  <= ent_off_in;
      end
   end

   assign dn_tok = tok_ff;

endmodule

### src/sorted_hash_string_table.sv
// Top level of the sorted hash string table: request intake, cell chain, result register
//
// Usage:
//   A request item (req_str_hash, req_str_length) is taken on req_valid && req_ready.
//   The block looks the hash up in a table kept sorted ascending; a hit returns the
//   stored offset and length (status 0), a miss inserts the entry (status 1), or
//   reports that the string area (status 2) or the table (status 3) is full.
//   csr_offset_limit is written on csr_valid && csr_ready; csr_ready is always high.
// Flow:
//   The request walks the chain of TABLE_DEPTH cells one cell per cycle, and the
//   insert shift rides along behind it. The result then passes through a pending
//   register and the rsp registers; no new item is taken until the pending result
//   has moved on into the rsp registers. One request is in the chain at a time.
// Reset:
//   Synchronous reset empties the table, zeroes next offset and sets the limit to
//   all ones. No clearing pass is needed; the block is ready the cycle after reset.
// Stalls:
//   The result waits in rsp registers while rsp_ready is low; the next request is
//   accepted and processed meanwhile and its result waits in a holding register.
`timescale 1ns / 1ps
module sorted_hash_string_table
   import sht_pkg::*;
#(
   parameter int TABLE_DEPTH        = SHT_TABLE_DEPTH,
   parameter int ENTRY_HEADER_BYTES = SHT_HEADER_BYTES
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_str_hash,
   input  logic [15:0] req_str_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_entry_offset,
   output logic [15:0] rsp_entry_length,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_offset_limit
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   logic [31:0]      limit_ff;
   logic [CNT_W-1:0] count_ff;
   logic [31:0]      next_off_ff;
   logic [31:0]      item_end_ff, item_end_in;
   logic [15:0]      item_len_ff;
   logic             busy_ff, busy_in;
   tok_type          head_ff, head_in;
   logic [33:0]      end_sum;
   logic             area_full, table_full;
   logic             req_fire, rsp_free;

   logic             pend_valid_ff, pend_valid_in;
   status_type       pend_stat_ff, pend_stat_in;
   logic [31:0]      pend_off_ff, pend_off_in;
   logic [15:0]      pend_len_ff, pend_len_in;
   logic             exit_hit, exit_added;

   logic             rsp_valid_ff;
   status_type       rsp_status_ff;
   logic [31:0]      rsp_off_ff;
   logic [15:0]      rsp_len_ff;

   tok_type          chain_tok [TABLE_DEPTH+1];
   logic             cell_valid [TABLE_DEPTH];
   tok_type          exit_tok;

   assign req_ready = !busy_ff;
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // room checks for a new entry, the sum kept without wrap-around
   assign end_sum    = 34'(next_off_ff) + 34'(ENTRY_HEADER_BYTES) + 34'(req_str_length);
   assign area_full  = end_sum >= 34'(limit_ff);
   assign table_full = count_ff == CNT_W'(TABLE_DEPTH);
   assign item_end_in = end_sum[31:0];

   // search token launched into the chain
   always_comb begin
      head_in      = head_ff;
      head_in.kind = TK_IDLE;
      if (req_fire) begin
         head_in.kind = TK_SEARCH;
         head_in.hash = req_str_hash;
         head_in.len  = req_str_length;
         head_in.off  = next_off_ff;
         if (area_full) begin
            head_in.stat = ST_AREA_FULL;
         end else if (table_full) begin
            head_in.stat = ST_TABLE_FULL;
         end else begin
            head_in.stat = ST_ADDED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.kind <= TK_IDLE;
      end else begin
         head_ff.kind <= head_in.kind;
      end
      head_ff.hash <= head_in.hash;
      head_ff.len  <= head_in.len;
      head_ff.off  <= head_in.off;
      head_ff.stat <= head_in.stat;
      if (req_fire) begin
         item_end_ff <= item_end_in;
         item_len_ff <= req_str_length;
      end
   end

   // cell chain; occupied slots are the lowest count_ff ones
   assign chain_tok[0] = head_ff;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      assign cell_valid[i] = count_ff > CNT_W'(i);
      sht_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ent_valid (cell_valid[i]),
         .up_tok    (chain_tok[i]),
         .dn_tok    (chain_tok[i+1])
      );
   end

   assign exit_tok = chain_tok[TABLE_DEPTH];

   // token leaving the chain end becomes the pending result
   always_comb begin
      exit_hit     = 1'b0;
      exit_added   = 1'b0;
      pend_stat_in = exit_tok.stat;
      pend_off_in  = exit_tok.off;
      pend_len_in  = exit_tok.len;
      unique case (exit_tok.kind)
         TK_SEARCH: begin
            // walked past every entry: no free slot left
            exit_hit    = 1'b1;
            pend_off_in = '0;
            pend_len_in = '0;
         end
         TK_DONE: begin
            exit_hit = 1'b1;
            if (exit_tok.stat == ST_ADDED) begin
               exit_added  = 1'b1;
               pend_off_in = next_off_ff;
               pend_len_in = item_len_ff;
            end
         end
         TK_IDLE, TK_SHIFT: begin
            exit_hit = 1'b0;
         end
         default: begin
            exit_hit = 1'b0;
         end
      endcase
   end

   // pending and busy control
   always_comb begin
      pend_valid_in = pend_valid_ff;
      busy_in       = busy_ff;
      if (pend_valid_ff && rsp_free) begin
         pend_valid_in = 1'b0;
         busy_in       = 1'b0;
      end
      if (exit_hit) begin
         pend_valid_in = 1'b1;
      end
      if (req_fire) begin
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         count_ff      <= '0;
         next_off_ff   <= '0;
         limit_ff      <= '1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         pend_valid_ff <= pend_valid_in;
         if (exit_added) begin
            count_ff    <= count_ff + CNT_W'(1);
            next_off_ff <= item_end_ff;
         end
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_offset_limit;
         end
         if (pend_valid_ff && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (exit_hit) begin
         pend_stat_ff <= pend_stat_in;
         pend_off_ff  <= pend_off_in;
         pend_len_ff  <= pend_len_in;
      end
      if (pend_valid_ff && rsp_free) begin
         rsp_status_ff <= pend_stat_ff;
         rsp_off_ff    <= pend_off_ff;
         rsp_len_ff    <= pend_len_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entry_offset = rsp_off_ff;
   assign rsp_entry_length = rsp_len_ff;

endmodule

### src/sht_checker.sv
// Port-level checker of the sorted hash string table and its bind
`timescale 1ns / 1ps
`include "sorted_hash_string_table_assert.svh"
module sht_checker
   import sht_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_entry_offset,
   input logic [15:0] rsp_entry_length
);

   // a held result keeps its payload
   `SHT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_entry_offset) && $stable(rsp_entry_length))

   // one request in flight: intake closes right after an accept
   `SHT_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready)

   // error results carry no offset or length
   `SHT_ASSERT_NOW(a_err_zero, clock, reset, rsp_valid && (rsp_status == ST_AREA_FULL || rsp_status == ST_TABLE_FULL), rsp_entry_offset == 32'd0 && rsp_entry_length == 16'd0)

   // reset leaves no result and an open intake
   `SHT_ASSERT_RST(a_reset_clear, clock, reset, !rsp_valid && req_ready)

endmodule

bind sorted_hash_string_table sht_checker u_sht_checker (.*);
